// File: rtl/obb_pair_separating_axis_test_macros.svh
// Assertion helpers included by the top-level file of this block.
`ifndef OBB_PAIR_SEPARATING_AXIS_TEST_MACROS_SVH
`define OBB_PAIR_SEPARATING_AXIS_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBBSAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OBBSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/obbsat_pkg.sv
`timescale 1ns / 1ps
package obbsat_pkg;

    localparam int NUM_AXES = 4;
    localparam int NUM_BOXES = 2;
    localparam logic signed [15:0] AXIS_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [31:0] a_center_x;
        logic signed [31:0] a_center_y;
        logic signed [15:0] a_axis_x;
        logic signed [15:0] a_axis_y;
        logic [30:0]        a_half_width;
        logic [30:0]        a_half_height;
        logic signed [31:0] b_center_x;
        logic signed [31:0] b_center_y;
        logic signed [15:0] b_axis_x;
        logic signed [15:0] b_axis_y;
        logic [30:0]        b_half_width;
        logic [30:0]        b_half_height;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
    } out_t;

    typedef struct packed {
        logic signed [63:0] a_lo;
        logic signed [63:0] a_hi;
        logic signed [63:0] b_lo;
        logic signed [63:0] b_hi;
        logic               nb;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
    } span_t;

    typedef struct packed {
        logic               hit;
        logic [62:0]        depth;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } best_t;

    function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
        logic signed [15:0] r;
        r = v;
        if (v > AXIS_ONE) r = AXIS_ONE;
        if (v < -AXIS_ONE) r = -AXIS_ONE;
        return r;
    endfunction

endpackage

// File: rtl/obbsat_proj.sv
`timescale 1ns / 1ps
module obbsat_proj (
    input  logic              clk,
    input  logic [3:0]        adv,
    input  obbsat_pkg::in_t   in_data,
    output obbsat_pkg::span_t span [obbsat_pkg::NUM_AXES]
);
    import obbsat_pkg::*;

    logic signed [31:0] cx [NUM_BOXES];
    logic signed [31:0] cy [NUM_BOXES];
    logic signed [15:0] ix [NUM_BOXES];
    logic signed [15:0] iy [NUM_BOXES];
    logic [30:0]        hw [NUM_BOXES];
    logic [30:0]        hh [NUM_BOXES];
    logic signed [15:0] axx [NUM_AXES];
    logic signed [15:0] axy [NUM_AXES];

    logic signed [47:0] pcx_reg [NUM_AXES][NUM_BOXES];
    logic signed [47:0] pcy_reg [NUM_AXES][NUM_BOXES];
    logic signed [31:0] pixax_reg [NUM_AXES][NUM_BOXES];
    logic signed [31:0] piyay_reg [NUM_AXES][NUM_BOXES];
    logic signed [31:0] piyax_reg [NUM_AXES][NUM_BOXES];
    logic signed [31:0] pixay_reg [NUM_AXES][NUM_BOXES];
    logic [30:0]        hw1_reg [NUM_BOXES];
    logic [30:0]        hh1_reg [NUM_BOXES];
    logic signed [15:0] ax1_reg [NUM_AXES];
    logic signed [15:0] ay1_reg [NUM_AXES];

    logic signed [48:0] mid2_reg [NUM_AXES][NUM_BOXES];
    logic [29:0]        di2_reg [NUM_AXES][NUM_BOXES];
    logic [29:0]        dj2_reg [NUM_AXES][NUM_BOXES];
    logic [30:0]        hw2_reg [NUM_BOXES];
    logic [30:0]        hh2_reg [NUM_BOXES];
    logic signed [15:0] ax2_reg [NUM_AXES];
    logic signed [15:0] ay2_reg [NUM_AXES];

    logic signed [48:0] mid3_reg [NUM_AXES][NUM_BOXES];
    logic [60:0]        ew3_reg [NUM_AXES][NUM_BOXES];
    logic [60:0]        eh3_reg [NUM_AXES][NUM_BOXES];
    logic signed [15:0] ax3_reg [NUM_AXES];
    logic signed [15:0] ay3_reg [NUM_AXES];

    logic signed [31:0] dsum_i [NUM_AXES][NUM_BOXES];
    logic signed [31:0] dsum_j [NUM_AXES][NUM_BOXES];
    logic signed [31:0] dabs_i [NUM_AXES][NUM_BOXES];
    logic signed [31:0] dabs_j [NUM_AXES][NUM_BOXES];
    logic [61:0]        ext [NUM_AXES][NUM_BOXES];
    logic signed [63:0] cen [NUM_AXES][NUM_BOXES];
    logic signed [63:0] lo [NUM_AXES][NUM_BOXES];
    logic signed [63:0] hi [NUM_AXES][NUM_BOXES];

    always_comb
    begin
        cx[0] = in_data.a_center_x;
        cy[0] = in_data.a_center_y;
        ix[0] = clamp_axis(in_data.a_axis_x);
        iy[0] = clamp_axis(in_data.a_axis_y);
        hw[0] = in_data.a_half_width;
        hh[0] = in_data.a_half_height;
        cx[1] = in_data.b_center_x;
        cy[1] = in_data.b_center_y;
        ix[1] = clamp_axis(in_data.b_axis_x);
        iy[1] = clamp_axis(in_data.b_axis_y);
        hw[1] = in_data.b_half_width;
        hh[1] = in_data.b_half_height;
        axx[0] = ix[0];
        axy[0] = iy[0];
        axx[1] = -iy[0];
        axy[1] = ix[0];
        axx[2] = ix[1];
        axy[2] = iy[1];
        axx[3] = -iy[1];
        axy[3] = ix[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                ax1_reg[k] <= axx[k];
                ay1_reg[k] <= axy[k];
                for (int b = 0; b < NUM_BOXES; b++)
                begin
                    pcx_reg[k][b]   <= 48'(cx[b]) * 48'(axx[k]);
                    pcy_reg[k][b]   <= 48'(cy[b]) * 48'(axy[k]);
                    pixax_reg[k][b] <= 32'(ix[b]) * 32'(axx[k]);
                    piyay_reg[k][b] <= 32'(iy[b]) * 32'(axy[k]);
                    piyax_reg[k][b] <= 32'(iy[b]) * 32'(axx[k]);
                    pixay_reg[k][b] <= 32'(ix[b]) * 32'(axy[k]);
                end
            end
            for (int b = 0; b < NUM_BOXES; b++)
            begin
                hw1_reg[b] <= hw[b];
                hh1_reg[b] <= hh[b];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            for (int b = 0; b < NUM_BOXES; b++)
            begin
                dsum_i[k][b] = pixax_reg[k][b] + piyay_reg[k][b];
                dsum_j[k][b] = pixay_reg[k][b] - piyax_reg[k][b];
                dabs_i[k][b] = (dsum_i[k][b] < 0) ? -dsum_i[k][b] : dsum_i[k][b];
                dabs_j[k][b] = (dsum_j[k][b] < 0) ? -dsum_j[k][b] : dsum_j[k][b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                ax2_reg[k] <= ax1_reg[k];
                ay2_reg[k] <= ay1_reg[k];
                for (int b = 0; b < NUM_BOXES; b++)
                begin
                    mid2_reg[k][b] <= 49'(pcx_reg[k][b]) + 49'(pcy_reg[k][b]);
                    di2_reg[k][b]  <= dabs_i[k][b][29:0];
                    dj2_reg[k][b]  <= dabs_j[k][b][29:0];
                end
            end
            for (int b = 0; b < NUM_BOXES; b++)
            begin
                hw2_reg[b] <= hw1_reg[b];
                hh2_reg[b] <= hh1_reg[b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                ax3_reg[k] <= ax2_reg[k];
                ay3_reg[k] <= ay2_reg[k];
                for (int b = 0; b < NUM_BOXES; b++)
                begin
                    mid3_reg[k][b] <= mid2_reg[k][b];
                    ew3_reg[k][b]  <= 61'(hw2_reg[b]) * 61'(di2_reg[k][b]);
                    eh3_reg[k][b]  <= 61'(hh2_reg[b]) * 61'(dj2_reg[k][b]);
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            for (int b = 0; b < NUM_BOXES; b++)
            begin
                ext[k][b] = 62'(ew3_reg[k][b]) + 62'(eh3_reg[k][b]);
                cen[k][b] = {{1{mid3_reg[k][b][48]}}, mid3_reg[k][b], 14'b0};
                lo[k][b]  = cen[k][b] - $signed({2'b00, ext[k][b]});
                hi[k][b]  = cen[k][b] + $signed({2'b00, ext[k][b]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                span[k].a_lo <= lo[k][0];
                span[k].a_hi <= hi[k][0];
                span[k].b_lo <= lo[k][1];
                span[k].b_hi <= hi[k][1];
                span[k].nb   <= mid3_reg[k][1] < mid3_reg[k][0];
                span[k].ax   <= ax3_reg[k];
                span[k].ay   <= ay3_reg[k];
            end
        end
    end

endmodule

// File: rtl/obbsat_select.sv
`timescale 1ns / 1ps
module obbsat_select (
    input  logic              clk,
    input  logic [3:0]        adv,
    input  obbsat_pkg::span_t span [obbsat_pkg::NUM_AXES],
    output obbsat_pkg::best_t best
);
    import obbsat_pkg::*;

    logic               sep5_reg [NUM_AXES];
    logic signed [63:0] lo5_reg [NUM_AXES];
    logic signed [63:0] hi5_reg [NUM_AXES];
    logic               nb5_reg [NUM_AXES];
    logic signed [15:0] ax5_reg [NUM_AXES];
    logic signed [15:0] ay5_reg [NUM_AXES];

    logic [62:0]        d6_reg [NUM_AXES];
    logic               sep6_reg;
    logic               nb6_reg [NUM_AXES];
    logic signed [15:0] ax6_reg [NUM_AXES];
    logic signed [15:0] ay6_reg [NUM_AXES];

    logic [62:0]        d7_reg [2];
    logic               nb7_reg [2];
    logic signed [15:0] ax7_reg [2];
    logic signed [15:0] ay7_reg [2];
    logic               sep7_reg;

    logic signed [63:0] diff [NUM_AXES];
    logic               take_hi;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                sep5_reg[k] <= (span[k].a_hi < span[k].b_lo) || (span[k].b_hi < span[k].a_lo);
                lo5_reg[k]  <= (span[k].a_lo > span[k].b_lo) ? span[k].a_lo : span[k].b_lo;
                hi5_reg[k]  <= (span[k].a_hi < span[k].b_hi) ? span[k].a_hi : span[k].b_hi;
                nb5_reg[k]  <= span[k].nb;
                ax5_reg[k]  <= span[k].ax;
                ay5_reg[k]  <= span[k].ay;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            diff[k] = hi5_reg[k] - lo5_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sep6_reg <= sep5_reg[0] || sep5_reg[1] || sep5_reg[2] || sep5_reg[3];
            for (int k = 0; k < NUM_AXES; k++)
            begin
                d6_reg[k]  <= diff[k][62:0];
                nb6_reg[k] <= nb5_reg[k];
                ax6_reg[k] <= ax5_reg[k];
                ay6_reg[k] <= ay5_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sep7_reg <= sep6_reg;
            for (int p = 0; p < 2; p++)
            begin
                if (d6_reg[2 * p + 1] < d6_reg[2 * p])
                begin
                    d7_reg[p]  <= d6_reg[2 * p + 1];
                    nb7_reg[p] <= nb6_reg[2 * p + 1];
                    ax7_reg[p] <= ax6_reg[2 * p + 1];
                    ay7_reg[p] <= ay6_reg[2 * p + 1];
                end
                else
                begin
                    d7_reg[p]  <= d6_reg[2 * p];
                    nb7_reg[p] <= nb6_reg[2 * p];
                    ax7_reg[p] <= ax6_reg[2 * p];
                    ay7_reg[p] <= ay6_reg[2 * p];
                end
            end
        end
    end

    assign take_hi = d7_reg[1] < d7_reg[0];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            best.hit <= !sep7_reg;
            if (take_hi)
            begin
                best.depth <= d7_reg[1];
                best.px    <= nb7_reg[1] ? -ax7_reg[1] : ax7_reg[1];
                best.py    <= nb7_reg[1] ? -ay7_reg[1] : ay7_reg[1];
            end
            else
            begin
                best.depth <= d7_reg[0];
                best.px    <= nb7_reg[0] ? -ax7_reg[0] : ax7_reg[0];
                best.py    <= nb7_reg[0] ? -ay7_reg[0] : ay7_reg[0];
            end
        end
    end

endmodule

// File: rtl/obbsat_push.sv
`timescale 1ns / 1ps
module obbsat_push (
    input  logic              clk,
    input  logic [2:0]        adv,
    input  obbsat_pkg::best_t best,
    output obbsat_pkg::out_t  out_data
);
    import obbsat_pkg::*;

    logic signed [15:0] comp [2];
    logic [14:0]        cmag [2];
    logic [48:0]        d14;

    logic               hit9_reg;
    logic               neg9_reg [2];
    logic [46:0]        plo9_reg [2];
    logic [31:0]        phi9_reg [2];

    logic               hit10_reg;
    logic               neg10_reg [2];
    logic [35:0]        q10_reg [2];

    logic [63:0]        rsum [2];
    logic [31:0]        sat [2];

    assign comp[0] = best.px;
    assign comp[1] = best.py;
    assign d14 = best.depth[62:14];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            cmag[c] = comp[c][15] ? 15'(-comp[c]) : comp[c][14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            hit9_reg <= best.hit;
            for (int c = 0; c < 2; c++)
            begin
                neg9_reg[c] <= comp[c][15];
                plo9_reg[c] <= 47'(d14[31:0]) * 47'(cmag[c]);
                phi9_reg[c] <= 32'(d14[48:32]) * 32'(cmag[c]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            rsum[c] = {17'b0, plo9_reg[c]} + {phi9_reg[c], 32'b0} + (64'd1 << 27);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            hit10_reg <= hit9_reg;
            for (int c = 0; c < 2; c++)
            begin
                neg10_reg[c] <= neg9_reg[c];
                q10_reg[c]   <= rsum[c][63:28];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (!hit10_reg)
                sat[c] = 32'd0;
            else if (neg10_reg[c])
                sat[c] = (q10_reg[c] > 36'd2147483648) ? 32'h8000_0000 : 32'(-q10_reg[c]);
            else
                sat[c] = (q10_reg[c] > 36'd2147483647) ? 32'h7FFF_FFFF : q10_reg[c][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            out_data.hit    <= hit10_reg;
            out_data.push_x <= sat[0];
            out_data.push_y <= sat[1];
        end
    end

endmodule

// File: rtl/obb_pair_separating_axis_test.sv
// Throughput: one box pair per cycle while the output is not stalled; each of the
// 11 stages holds its beat only while the stage after it is full and stalled, so
// bubbles close up behind a stalled output.
// Reset clears the valid bit of every stage; the data registers are not reset.
`timescale 1ns / 1ps
`include "obb_pair_separating_axis_test_macros.svh"
module obb_pair_separating_axis_test (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  obbsat_pkg::in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output obbsat_pkg::out_t out_data
);
    import obbsat_pkg::*;

    localparam int NS = 11;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] adv;
    span_t         span [NUM_AXES];
    best_t         best;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || out_ready;
        for (int j = NS - 2; j >= 0; j--)
        begin
            adv[j] = !v_reg[j] || adv[j+1];
        end
    end

    always_comb
    begin
        v_next = {v_reg[NS-2:0], in_valid};
        for (int j = 0; j < NS; j++)
        begin
            if (!adv[j]) v_next[j] = v_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];

    obbsat_proj u_proj (
        .clk     (clk),
        .adv     (adv[3:0]),
        .in_data (in_data),
        .span    (span)
    );

    obbsat_select u_select (
        .clk  (clk),
        .adv  (adv[7:4]),
        .span (span),
        .best (best)
    );

    obbsat_push u_push (
        .clk      (clk),
        .adv      (adv[10:8]),
        .best     (best),
        .out_data (out_data)
    );

    `OBBSAT_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_data.hit, out_data.push_x == 32'sd0 && out_data.push_y == 32'sd0, "push not zero on a miss")
    `OBBSAT_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")
    `OBBSAT_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, v_reg[0], "accepted beat lost at first stage")

endmodule

// File: tb/obb_pair_separating_axis_test_checker.sv
`timescale 1ns / 1ps
module obb_pair_separating_axis_test_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  obbsat_pkg::in_t  in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  obbsat_pkg::out_t out_data,
    output int               fail_count,
    output int               pending
);
    import obbsat_pkg::*;

    localparam int DEPTH = 32;

    out_t       contact_fifo [DEPTH];
    logic [4:0] wr_ptr;
    logic [4:0] rd_ptr;
    int         count;

    function automatic longint sat_axis(logic signed [15:0] v);
        longint r;
        r = v;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic longint absl(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] push_comp(longint d14, longint comp);
        longint prod;
        longint r;
        logic neg;
        prod = d14 * comp;
        neg = prod < 0;
        r = ((neg ? -prod : prod) + (64'sd1 <<< 27)) >>> 28;
        if (neg) r = -r;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic out_t predict_contact(in_t b);
        longint acx, acy, aix, aiy, ahw, ahh, bcx, bcy, bix, biy, bhw, bhh;
        longint axx[4], axy[4];
        longint best, bx, by, alo, ahi, blo, bhi, lo, hi, depth, mid, ext;
        out_t r;
        acx = b.a_center_x; acy = b.a_center_y;
        aix = sat_axis(b.a_axis_x); aiy = sat_axis(b.a_axis_y);
        ahw = {33'd0, b.a_half_width}; ahh = {33'd0, b.a_half_height};
        bcx = b.b_center_x; bcy = b.b_center_y;
        bix = sat_axis(b.b_axis_x); biy = sat_axis(b.b_axis_y);
        bhw = {33'd0, b.b_half_width}; bhh = {33'd0, b.b_half_height};
        axx = '{aix, -aiy, bix, -biy};
        axy = '{aiy, aix, biy, bix};
        best = 0; bx = 0; by = 0;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            mid = (acx * axx[k] + acy * axy[k]) * 16384;
            ext = ahw * absl(aix * axx[k] + aiy * axy[k])
                + ahh * absl(-aiy * axx[k] + aix * axy[k]);
            alo = mid - ext; ahi = mid + ext;
            mid = (bcx * axx[k] + bcy * axy[k]) * 16384;
            ext = bhw * absl(bix * axx[k] + biy * axy[k])
                + bhh * absl(-biy * axx[k] + bix * axy[k]);
            blo = mid - ext; bhi = mid + ext;
            if (ahi < blo || bhi < alo) return r;
            lo = (alo > blo) ? alo : blo;
            hi = (ahi < bhi) ? ahi : bhi;
            depth = hi - lo;
            if (k == 0 || depth < best)
            begin
                best = depth; bx = axx[k]; by = axy[k];
            end
        end
        if ((bcx - acx) * bx + (bcy - acy) * by < 0)
        begin
            bx = -bx; by = -by;
        end
        r.hit = 1'b1;
        r.push_x = push_comp(longint'(unsigned'(best) >> 14), bx);
        r.push_y = push_comp(longint'(unsigned'(best) >> 14), by);
        return r;
    endfunction

    assign pending = count;

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        int errs;
        int delta;
        if (!rst_n)
        begin
            fail_count <= 0;
            count <= 0;
            wr_ptr <= '0;
            rd_ptr <= '0;
        end
        else
        begin
            errs = 0;
            delta = 0;
            if (in_valid && in_ready)
            begin
                if (count >= DEPTH)
                begin
                    if (fail_count < 10) $display("too many beats in flight");
                    errs = errs + 1;
                end
                else
                begin
                    contact_fifo[wr_ptr] <= predict_contact(in_data);
                    wr_ptr <= wr_ptr + 5'd1;
                    delta = 1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (count == 0)
                begin
                    if (fail_count + errs < 10) $display("unexpected beat %h", out_data);
                    errs = errs + 1;
                end
                else
                begin
                    want = contact_fifo[rd_ptr];
                    rd_ptr <= rd_ptr + 5'd1;
                    delta = delta - 1;
                    if (want.hit !== out_data.hit || want.push_x !== out_data.push_x
                        || want.push_y !== out_data.push_y)
                    begin
                        if (fail_count + errs < 10)
                            $display("mismatch: expected hit %0d push %0d,%0d got %0d %0d,%0d",
                                want.hit, want.push_x, want.push_y, out_data.hit,
                                out_data.push_x, out_data.push_y);
                        errs = errs + 1;
                    end
                end
            end
            count <= count + delta;
            fail_count <= fail_count + errs;
        end
    end
endmodule

// File: tb/obb_pair_separating_axis_test_test.sv
`timescale 1ns / 1ps
module obb_pair_separating_axis_test_test;
    import obbsat_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int   fail_count;
    int   pending;
    bit   quiet_phase;
    bit   sending_done;
    int   idle_cycles;

    obb_pair_separating_axis_test u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    obb_pair_separating_axis_test_checker u_check (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h7fff ^ ($urandom_range(0, 1) ? 16'hffff : 16'h0);
            1: return 16'($urandom());
            2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom();
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [30:0] rand_half();
        case ($urandom_range(0, 4))
            0: return 31'($urandom());
            default: return 31'($urandom_range(0, 600000));
        endcase
    endfunction

    function automatic in_t rand_pair();
        in_t p;
        p.a_center_x = rand_pos(); p.a_center_y = rand_pos();
        p.a_axis_x = rand_axis(); p.a_axis_y = rand_axis();
        p.a_half_width = rand_half(); p.a_half_height = rand_half();
        p.b_axis_x = rand_axis(); p.b_axis_y = rand_axis();
        p.b_half_width = rand_half(); p.b_half_height = rand_half();
        if ($urandom_range(0, 2) != 0)
        begin
            p.b_center_x = p.a_center_x + 32'($signed($urandom_range(0, 400000)) - 200000);
            p.b_center_y = p.a_center_y + 32'($signed($urandom_range(0, 400000)) - 200000);
        end
        else
        begin
            p.b_center_x = rand_pos(); p.b_center_y = rand_pos();
        end
        return p;
    endfunction

    function automatic in_t fixed_pair(int n);
        in_t p;
        p = '0;
        p.a_axis_x = 16'sd16384; p.b_axis_x = 16'sd16384;
        p.a_half_width = 31'd65536; p.a_half_height = 31'd65536;
        p.b_half_width = 31'd65536; p.b_half_height = 31'd65536;
        case (n)
            0: p.b_center_x = 32'sd131072;
            1: p.b_center_x = 32'sd131073;
            2: p.b_center_x = -32'sd65536;
            3: p = '0;
            4: begin p.a_axis_x = 16'sd0; p.b_axis_x = 16'sd0; end
            5: begin p.a_axis_x = 16'sh7fff; p.b_axis_y = 16'sh8000; end
            6: p = '1;
            7: begin
                p.a_center_x = 32'h80000000; p.b_center_x = 32'h7fffffff;
                p.a_half_width = '1; p.b_half_width = '1;
                p.a_half_height = '1; p.b_half_height = '1;
            end
            8: begin
                p.a_half_width = '1; p.a_half_height = '1;
                p.b_half_width = '1; p.b_half_height = '1;
                p.b_center_y = 32'sd5;
            end
            9: begin
                p.a_axis_x = 16'sd11585; p.a_axis_y = 16'sd11585;
                p.b_center_y = -32'sd70000;
            end
            10: begin p.b_axis_x = -16'sd16384; p.b_center_x = 32'sd100; end
            11: begin p.a_center_y = 32'h7fffffff; p.b_center_y = 32'h80000000; end
            default: p = rand_pair();
        endcase
        return p;
    endfunction

    task automatic send_pair(in_t p);
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        in_valid = 0;
        in_data = '0;
        rst_n = 0;
        sending_done = 0;
        quiet_phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int n = 0; n < 20; n++) send_pair(fixed_pair(n));
        for (int n = 0; n < 1200; n++)
        begin
            if (n > 1000) quiet_phase = 1;
            send_pair(rand_pair());
            if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        sending_done = 1;
    end

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        out_ready <= 1;
        repeat (60) @(posedge clk);
        out_ready <= 0;
        repeat (80) @(posedge clk);
        forever
        begin
            out_ready <= 1;
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles > 2000)
            begin
                $display("tb: failure");
                $finish;
            end
            if (sending_done && pending == 0)
            begin
                repeat (30) @(posedge clk);
                if (fail_count == 0 && pending == 0)
                    $display("tb: success");
                else
                    $display("tb: failure");
                $finish;
            end
        end
    end
endmodule
